@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mat_pkg.sv @@
// ----------------------------------------------------------------------------
// mat_pkg
// Widths, constants and types shared by the angle tracker modules.
// ----------------------------------------------------------------------------
package mat_pkg;

  localparam int FRAME_BITS     = 18;
  localparam int REV_COUNT_BITS = 24;

  localparam int ANGLE_BITS     = 12;
  localparam int STATUS_BITS    = 6;
  localparam int SENS_BITS      = 16;
  localparam int SENS_FRAC_BITS = 12;
  localparam int THRESH_BITS    = 12;
  localparam int INTERVAL_BITS  = 16;
  localparam int TIME_BITS      = 32;
  localparam int POS_BITS       = 41;
  localparam int VEL_BITS       = 32;
  localparam int VEL_FRAC_BITS  = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Multiplier: |revs*4096 + angle| times the sensitivity
  localparam int MAG_BITS        = REV_COUNT_BITS + ANGLE_BITS;
  localparam int PROD_BITS       = MAG_BITS + SENS_BITS;
  localparam int SCALED_MAG_BITS = PROD_BITS - SENS_FRAC_BITS;
  localparam int MUL_CNT_BITS    = $clog2(SENS_BITS);

  // Divider: |delta| * 256 over elapsed ms
  localparam int DELTA_BITS    = POS_BITS + 1;
  localparam int DIVIDEND_BITS = DELTA_BITS + VEL_FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

  localparam int SAT_CMP_BITS = SCALED_MAG_BITS + POS_BITS + 1;

  localparam logic [SENS_BITS-1:0]     SENS_RESET     = SENS_BITS'(4096);
  localparam logic [THRESH_BITS-1:0]   HIGH_RESET     = THRESH_BITS'(3896);
  localparam logic [THRESH_BITS-1:0]   LOW_RESET      = THRESH_BITS'(200);
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(20);

  localparam logic signed [REV_COUNT_BITS-1:0] REV_MAX = {1'b0, {(REV_COUNT_BITS-1){1'b1}}};
  localparam logic signed [REV_COUNT_BITS-1:0] REV_MIN = {1'b1, {(REV_COUNT_BITS-1){1'b0}}};
  localparam logic signed [POS_BITS-1:0]       POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0]       POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic signed [VEL_BITS-1:0]       VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic signed [VEL_BITS-1:0]       VEL_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};

  localparam logic [SAT_CMP_BITS-1:0] POS_LIM_POS =
    (SAT_CMP_BITS'(1) << (POS_BITS-1)) - SAT_CMP_BITS'(1);
  localparam logic [SAT_CMP_BITS-1:0] POS_LIM_NEG = SAT_CMP_BITS'(1) << (POS_BITS-1);
  localparam logic [DIVIDEND_BITS-1:0] VEL_LIM_POS =
    (DIVIDEND_BITS'(1) << (VEL_BITS-1)) - DIVIDEND_BITS'(1);
  localparam logic [DIVIDEND_BITS-1:0] VEL_LIM_NEG = DIVIDEND_BITS'(1) << (VEL_BITS-1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_WRAP_HIGH   = 2'd1,
    REG_WRAP_LOW    = 2'd2,
    REG_INTERVAL    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SCALE,
    ST_PREP,
    ST_DIV,
    ST_SUM
  } state_t;

endpackage

@@ rtl/mat_mul.sv @@
// ----------------------------------------------------------------------------
// mat_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mat_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mat_pkg::MAG_BITS-1:0]   multiplicand,
  input  logic [mat_pkg::SENS_BITS-1:0]  multiplier,
  output logic                           done,
  output logic [mat_pkg::PROD_BITS-1:0]  product
);
  import mat_pkg::*;

  logic                    busy;
  logic [MUL_CNT_BITS-1:0] count;
  logic [MAG_BITS-1:0]     mcand;
  logic [MAG_BITS-1:0]     hi;
  logic [SENS_BITS-1:0]    lo;
  logic [MAG_BITS:0]       sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(MAG_BITS+1){1'b0}});
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= MUL_CNT_BITS'(SENS_BITS-1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - MUL_CNT_BITS'(1);
      end
    end
  end

  // product shifts down as multiplier bits are consumed from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= multiplicand;
      hi    <= '0;
      lo    <= multiplier;
    end else if (busy) begin
      hi <= sum[MAG_BITS:1];
      lo <= {sum[0], lo[SENS_BITS-1:1]};
    end
  end

endmodule

@@ rtl/mat_div.sv @@
// ----------------------------------------------------------------------------
// mat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mat_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mat_pkg::DIVIDEND_BITS-1:0] dividend,
  input  logic [mat_pkg::TIME_BITS-1:0]     divisor,
  output logic                              done,
  output logic [mat_pkg::DIVIDEND_BITS-1:0] quotient
);
  import mat_pkg::*;

  logic                     busy;
  logic [DIV_CNT_BITS-1:0]  count;
  logic [TIME_BITS-1:0]     dvs;
  logic [TIME_BITS-1:0]     rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [TIME_BITS:0]       shifted;
  logic [TIME_BITS:0]       diff;

  assign shifted  = {rem, quo[DIVIDEND_BITS-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_BITS'(DIVIDEND_BITS-1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - DIV_CNT_BITS'(1);
      end
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[TIME_BITS]) begin
        rem <= diff[TIME_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[TIME_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/multiturn_angle_tracker_top.sv @@
// A frame taken in ST_IDLE runs through ST_LOAD, ST_MUL (serial multiply), ST_SCALE,
// ST_PREP, ST_DIV (serial divide, velocity update only) and ST_SUM, which waits for a
// free result register; in_stall is high and no new frame is taken until ST_IDLE returns.
// Reset (rst, synchronous): registers to defaults, revolution state cleared, no result.
// ----------------------------------------------------------------------------
// multiturn_angle_tracker_top
// Encoder frame decode, revolution counting, scaled position and velocity.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiturn_angle_tracker_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [mat_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [mat_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [mat_pkg::FRAME_BITS-1:0]          frame,
  input  logic [mat_pkg::TIME_BITS-1:0]           time_ms,
  input  logic                                    mode,
  input  logic signed [mat_pkg::POS_BITS-1:0]     desired_position,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [mat_pkg::ANGLE_BITS-1:0]          angle,
  output logic signed [mat_pkg::POS_BITS-1:0]     absolute_position,
  output logic signed [mat_pkg::REV_COUNT_BITS-1:0] revolutions,
  output logic signed [mat_pkg::VEL_BITS-1:0]     velocity,
  output logic [mat_pkg::STATUS_BITS-1:0]         sensor_status
);
  import mat_pkg::*;

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic [POS_BITS:0] v);
    if (v[POS_BITS] != v[POS_BITS-1]) begin
      return v[POS_BITS] ? POS_MIN : POS_MAX;
    end
    return v[POS_BITS-1:0];
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_scaled(
    input logic [SCALED_MAG_BITS-1:0] mag,
    input logic                       neg
  );
    logic [SAT_CMP_BITS-1:0] m;
    logic [POS_BITS-1:0]     v;
    m = SAT_CMP_BITS'(mag);
    v = POS_BITS'(m);
    if (neg && m > POS_LIM_NEG) return POS_MIN;
    if (!neg && m > POS_LIM_POS) return POS_MAX;
    return neg ? (~v + POS_BITS'(1)) : v;
  endfunction

  function automatic logic signed [VEL_BITS-1:0] sat_vel(
    input logic [DIVIDEND_BITS-1:0] q,
    input logic                     neg
  );
    logic [VEL_BITS-1:0] v;
    v = VEL_BITS'(q);
    if (neg && q > VEL_LIM_NEG) return VEL_MIN;
    if (!neg && q > VEL_LIM_POS) return VEL_MAX;
    return neg ? (~v + VEL_BITS'(1)) : v;
  endfunction

  state_t state, state_next;

  // configuration
  logic [SENS_BITS-1:0]     sensitivity;
  logic [THRESH_BITS-1:0]   wrap_high;
  logic [THRESH_BITS-1:0]   wrap_low;
  logic [INTERVAL_BITS-1:0] interval;

  // tracker state
  logic [ANGLE_BITS-1:0]            previous_angle;
  logic                             primed;
  logic signed [REV_COUNT_BITS-1:0] rev_count;
  logic signed [POS_BITS-1:0]       offset;
  logic signed [POS_BITS-1:0]       base_pos;
  logic [TIME_BITS-1:0]             base_time;
  logic signed [VEL_BITS-1:0]       cur_vel;

  // per-item working registers
  logic [ANGLE_BITS-1:0]      cur_angle;
  logic [STATUS_BITS-1:0]     status_q;
  logic [TIME_BITS-1:0]       time_q;
  logic                       mode_q;
  logic signed [POS_BITS-1:0] desired_q;
  logic signed [POS_BITS-1:0] scaled;
  logic                       delta_neg;

  logic                          in_xfer;
  logic [ANGLE_BITS-1:0]         in_angle;
  logic signed [REV_COUNT_BITS-1:0] rev_next;
  logic [MAG_BITS-1:0]           raw;
  logic [MAG_BITS-1:0]           raw_mag;
  logic                          mul_start;
  logic                          mul_done;
  logic [PROD_BITS-1:0]          mul_product;
  logic [TIME_BITS-1:0]          elapsed;
  logic                          vel_update;
  logic [DELTA_BITS-1:0]         delta;
  logic [DELTA_BITS-1:0]         delta_mag;
  logic                          div_start;
  logic                          div_done;
  logic [DIVIDEND_BITS-1:0]      div_quotient;
  logic                          load_out;

  assign in_xfer  = in_valid && !in_stall;
  assign in_angle = frame[FRAME_BITS-1 -: ANGLE_BITS];

  // wrap detection; the first frame after reset only primes the previous angle
  always_comb begin
    rev_next = rev_count;
    if (primed) begin
      if (previous_angle > wrap_high && in_angle < wrap_low) begin
        if (rev_count != REV_MAX) rev_next = rev_count + REV_COUNT_BITS'(1);
      end else if (previous_angle < wrap_low && in_angle > wrap_high) begin
        if (rev_count != REV_MIN) rev_next = rev_count - REV_COUNT_BITS'(1);
      end
    end
  end

  assign raw     = {rev_count, cur_angle};
  assign raw_mag = rev_count[REV_COUNT_BITS-1] ? (~raw + MAG_BITS'(1)) : raw;

  assign elapsed    = time_q - base_time;
  assign vel_update = (elapsed >= TIME_BITS'(interval)) && (elapsed != '0);

  assign delta     = {scaled[POS_BITS-1], scaled} - {base_pos[POS_BITS-1], base_pos};
  assign delta_mag = delta[DELTA_BITS-1] ? (~delta + DELTA_BITS'(1)) : delta;

  mat_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (raw_mag),
    .multiplier   (sensitivity),
    .done         (mul_done),
    .product      (mul_product)
  );

  mat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({delta_mag, {VEL_FRAC_BITS{1'b0}}}),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_PREP;
      end
      ST_PREP: begin
        if (vel_update) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_SUM;
      end
      ST_SUM: begin
        // result register free, or its transfer completes this cycle
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration, tracker state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity    <= SENS_RESET;
      wrap_high      <= HIGH_RESET;
      wrap_low       <= LOW_RESET;
      interval       <= INTERVAL_RESET;
      previous_angle <= '0;
      primed         <= 1'b0;
      rev_count      <= '0;
      offset         <= '0;
      base_pos       <= '0;
      base_time      <= '0;
      cur_vel        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SENSITIVITY: sensitivity <= cfg_data[SENS_BITS-1:0];
          REG_WRAP_HIGH:   wrap_high   <= cfg_data[THRESH_BITS-1:0];
          REG_WRAP_LOW:    wrap_low    <= cfg_data[THRESH_BITS-1:0];
          REG_INTERVAL:    interval    <= cfg_data[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        previous_angle <= in_angle;
        primed         <= 1'b1;
        rev_count      <= rev_next;
      end
      if (state == ST_PREP && mode_q) begin
        offset <= sat_pos({desired_q[POS_BITS-1], desired_q} - {scaled[POS_BITS-1], scaled});
      end
      if (state == ST_DIV && div_done) begin
        cur_vel   <= sat_vel(div_quotient, delta_neg);
        base_time <= time_q;
        base_pos  <= scaled;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_angle <= in_angle;
      status_q  <= frame[STATUS_BITS-1:0];
      time_q    <= time_ms;
      mode_q    <= mode;
      desired_q <= desired_position;
    end
    if (state == ST_SCALE) begin
      scaled <= sat_scaled(mul_product[PROD_BITS-1:SENS_FRAC_BITS],
                           rev_count[REV_COUNT_BITS-1]);
    end
    if (state == ST_PREP) begin
      delta_neg <= delta[DELTA_BITS-1];
    end
    if (load_out) begin
      angle             <= cur_angle;
      absolute_position <= sat_pos({scaled[POS_BITS-1], scaled} + {offset[POS_BITS-1], offset});
      revolutions       <= rev_count;
      velocity          <= cur_vel;
      sensor_status     <= status_q;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_xfer, in_stall, "input taken while busy")
  `ASSERT_IMPLIES(a_mul_done_in_mul, clk, rst, mul_done, state == ST_MUL, "stray multiply done")
  `ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_done, state == ST_DIV, "stray divide done")
  `ASSERT_NEXT(a_revs_hold, clk, rst, !in_xfer, $stable(rev_count), "revs moved without transfer")

endmodule

@@ verif/angle_tracker_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_tracker_checker
// Watches the frame and result channels of the angle tracker, keeps its own
// copy of the revolution, offset and velocity state, and compares every
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module angle_tracker_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_write,
  input  logic [mat_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [mat_pkg::CFG_DATA_BITS-1:0]         cfg_data,
  input  logic                                      in_valid,
  input  logic                                      in_stall,
  input  logic [mat_pkg::FRAME_BITS-1:0]            frame,
  input  logic [mat_pkg::TIME_BITS-1:0]             time_ms,
  input  logic                                      mode,
  input  logic signed [mat_pkg::POS_BITS-1:0]       desired_position,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic [mat_pkg::ANGLE_BITS-1:0]            angle,
  input  logic signed [mat_pkg::POS_BITS-1:0]       absolute_position,
  input  logic signed [mat_pkg::REV_COUNT_BITS-1:0] revolutions,
  input  logic signed [mat_pkg::VEL_BITS-1:0]       velocity,
  input  logic [mat_pkg::STATUS_BITS-1:0]           sensor_status,
  output int                                        mismatch_count,
  output int                                        results_due
);
  import mat_pkg::*;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]            angle;
    logic signed [POS_BITS-1:0]       abs_pos;
    logic signed [REV_COUNT_BITS-1:0] revs;
    logic signed [VEL_BITS-1:0]       vel;
    logic [STATUS_BITS-1:0]           status;
  } track_sample_t;

  logic [SENS_BITS-1:0]             sens_q;
  logic [THRESH_BITS-1:0]           high_q;
  logic [THRESH_BITS-1:0]           low_q;
  logic [INTERVAL_BITS-1:0]         interval_q;

  logic [ANGLE_BITS-1:0]            last_angle;
  bit                               primed;
  logic signed [REV_COUNT_BITS-1:0] turns;
  longint                           offset_pos;
  longint                           base_pos;
  logic [TIME_BITS-1:0]             base_ms;
  logic signed [VEL_BITS-1:0]       speed;

  track_sample_t                    samples_due[$];
  int                               fails = 0;

  function automatic longint clamp_pos(input longint v);
    if (v > longint'(POS_MAX)) return longint'(POS_MAX);
    if (v < longint'(POS_MIN)) return longint'(POS_MIN);
    return v;
  endfunction

  // Advances the tracker state by one frame and returns the result it reports
  function automatic track_sample_t track_frame(input logic [FRAME_BITS-1:0] frm,
                                                input logic [TIME_BITS-1:0] now,
                                                input logic md,
                                                input logic signed [POS_BITS-1:0] want);
    logic [ANGLE_BITS-1:0] ang;
    logic [TIME_BITS-1:0]  elapsed;
    longint                scaled;
    longint                quot;
    track_sample_t         res;
    ang = frm[FRAME_BITS-1 -: ANGLE_BITS];
    if (primed) begin
      if (last_angle > high_q && ang < low_q) begin
        if (turns != REV_MAX) turns += 1;
      end else if (last_angle < low_q && ang > high_q) begin
        if (turns != REV_MIN) turns -= 1;
      end
    end
    primed = 1'b1;
    last_angle = ang;

    // signed division truncates toward zero, as the scaling requires
    scaled = clamp_pos(((longint'(ang) + longint'(turns) * 4096) * longint'(sens_q)) / 4096);

    elapsed = now - base_ms;
    if (elapsed >= interval_q && elapsed != 0) begin
      quot = ((scaled - base_pos) * 256) / longint'(elapsed);
      if (quot > longint'(VEL_MAX)) quot = longint'(VEL_MAX);
      if (quot < longint'(VEL_MIN)) quot = longint'(VEL_MIN);
      speed = VEL_BITS'(quot);
      base_ms = now;
      base_pos = scaled;
    end

    if (md) offset_pos = clamp_pos(longint'(want) - scaled);

    res.angle   = ang;
    res.abs_pos = POS_BITS'(clamp_pos(scaled + offset_pos));
    res.revs    = turns;
    res.vel     = speed;
    res.status  = frm[STATUS_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    track_sample_t due;
    if (rst) begin
      sens_q     = SENS_RESET;
      high_q     = HIGH_RESET;
      low_q      = LOW_RESET;
      interval_q = INTERVAL_RESET;
      last_angle = '0;
      primed     = 1'b0;
      turns      = '0;
      offset_pos = 0;
      base_pos   = 0;
      base_ms    = '0;
      speed      = '0;
      samples_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_SENSITIVITY: sens_q     = cfg_data[SENS_BITS-1:0];
          REG_WRAP_HIGH:   high_q     = cfg_data[THRESH_BITS-1:0];
          REG_WRAP_LOW:    low_q      = cfg_data[THRESH_BITS-1:0];
          REG_INTERVAL:    interval_q = cfg_data[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        samples_due.push_back(track_frame(frame, time_ms, mode, desired_position));
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result transfer with none outstanding, angle=%0d pos=%0d",
                     $time, angle, absolute_position);
        end else begin
          due = samples_due.pop_front();
          if (angle !== due.angle || absolute_position !== due.abs_pos ||
              revolutions !== due.revs || velocity !== due.vel ||
              sensor_status !== due.status) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch exp angle=%0d pos=%0d revs=%0d vel=%0d st=%0h",
                       $time, due.angle, due.abs_pos, due.revs, due.vel, due.status,
                       "\n            got angle=%0d pos=%0d revs=%0d vel=%0d st=%0h",
                       angle, absolute_position, revolutions, velocity, sensor_status);
          end
        end
      end
    end
    results_due    <= samples_due.size();
    mismatch_count <= fails;
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives encoder frames and register settings into the angle tracker with
// random gaps and output stalls; the checker alongside judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import mat_pkg::*;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]        cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]         cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [FRAME_BITS-1:0]            frame = '0;
  logic [TIME_BITS-1:0]             time_ms = '0;
  logic                             mode = 1'b0;
  logic signed [POS_BITS-1:0]       desired_position = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ANGLE_BITS-1:0]            angle;
  logic signed [POS_BITS-1:0]       absolute_position;
  logic signed [REV_COUNT_BITS-1:0] revolutions;
  logic signed [VEL_BITS-1:0]       velocity;
  logic [STATUS_BITS-1:0]           sensor_status;

  int                               mismatch_count;
  int                               results_due;

  bit                               calm = 1'b0;   // no gaps and no stalls
  int                               sent = 0;
  int                               wheel = 0;     // angle of the smooth rotation
  logic [TIME_BITS-1:0]             now_ms = '0;
  logic [THRESH_BITS-1:0]           cur_high = HIGH_RESET;
  logic [THRESH_BITS-1:0]           cur_low = LOW_RESET;

  multiturn_angle_tracker_top DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .frame             (frame),
    .time_ms           (time_ms),
    .mode              (mode),
    .desired_position  (desired_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .angle             (angle),
    .absolute_position (absolute_position),
    .revolutions       (revolutions),
    .velocity          (velocity),
    .sensor_status     (sensor_status)
  );

  angle_tracker_checker tracker_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .frame             (frame),
    .time_ms           (time_ms),
    .mode              (mode),
    .desired_position  (desired_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .angle             (angle),
    .absolute_position (absolute_position),
    .revolutions       (revolutions),
    .velocity          (velocity),
    .sensor_status     (sensor_status),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 16);
  end

  initial begin
    #15_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_frame(input logic [FRAME_BITS-1:0] frm, input logic md,
                            input logic signed [POS_BITS-1:0] want);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    frame            <= frm;
    time_ms          <= now_ms;
    mode             <= md;
    desired_position <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_angle(input int ang, input logic md,
                            input logic signed [POS_BITS-1:0] want);
    send_frame({ANGLE_BITS'(ang), STATUS_BITS'($urandom)}, md, want);
  endtask

  // Lets every outstanding result arrive before anything else happens
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] sens, input logic [11:0] hi,
                              input logic [11:0] lo, input logic [15:0] ivl);
    cfg_write <= 1'b1;
    cfg_index <= REG_SENSITIVITY;
    cfg_data  <= sens;
    @(posedge clk);
    cfg_index <= REG_WRAP_HIGH;
    cfg_data  <= CFG_DATA_BITS'(hi);
    @(posedge clk);
    cfg_index <= REG_WRAP_LOW;
    cfg_data  <= CFG_DATA_BITS'(lo);
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_data  <= ivl;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_high = hi;
    cur_low  = lo;
  endtask

  function automatic int near_top();
    if (cur_high == '1) return 4095;
    return $urandom_range(4095, int'(cur_high) + 1);
  endfunction

  function automatic int near_bottom();
    if (cur_low == '0) return 0;
    return $urandom_range(0, int'(cur_low) - 1);
  endfunction

  function automatic logic signed [POS_BITS-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:          return POS_MAX;
      1:          return POS_MIN;
      2, 3, 4, 5: return POS_BITS'({$urandom, $urandom});
      default:    return POS_BITS'(longint'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic step_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) now_ms += $urandom;
    else if (r >= 8) now_ms += $urandom_range(1, 25);
  endtask

  task automatic mixed_item();
    int                         pick;
    logic                       md;
    logic signed [POS_BITS-1:0] want;
    pick = $urandom_range(0, 99);
    md   = ($urandom_range(0, 99) < 6);
    want = pick_target();
    step_clock();
    if (pick < 10) begin
      send_frame(FRAME_BITS'($urandom), md, want);
    end else if (pick < 30) begin
      // deliberate crossing of the turn boundary, either direction
      if ($urandom_range(0, 1)) begin
        send_angle(near_top(), 1'b0, want);
        step_clock();
        send_angle(near_bottom(), md, want);
      end else begin
        send_angle(near_bottom(), 1'b0, want);
        step_clock();
        send_angle(near_top(), md, want);
      end
    end else begin
      wheel = (wheel + int'($urandom_range(0, 600)) - 300) & 4095;
      send_angle(wheel, md, want);
    end
  endtask

  // Crosses the turn boundary many times, alternately up and down, with the clock frozen, then adds one ms
  task automatic sprint(input bit upward);
    repeat (150) begin
      if (upward) begin
        send_angle(near_top(), 1'b0, pick_target());
        send_angle(near_bottom(), 1'b0, pick_target());
      end else begin
        send_angle(near_bottom(), 1'b0, pick_target());
        send_angle(near_top(), 1'b0, pick_target());
      end
    end
    now_ms += 1;
    send_angle(upward ? near_bottom() : near_top(), 1'b0, '0);
  endtask

  initial begin
    int          phase_no;
    int          target;
    logic [15:0] sens_v;
    logic [15:0] ivl_v;
    logic [11:0] hi_v;
    logic [11:0] lo_v;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values
    now_ms = 0;             send_angle(4000, 1'b0, '0);   // only primes, no turn
    now_ms = 5;             send_angle(100, 1'b0, '0);    // turn up
    now_ms = 25;            send_angle(4095, 1'b0, '0);   // turn down, velocity update
    now_ms = 25;            send_angle(0, 1'b0, '0);      // no elapsed time
    now_ms = 30;            send_angle(199, 1'b0, '0);
    now_ms = 60;            send_angle(3897, 1'b0, '0);   // just inside both bounds
    now_ms = 61;            send_angle(3896, 1'b0, '0);
    now_ms = 62;            send_angle(200, 1'b0, '0);    // on the bounds: no turn
    now_ms = 63;            send_angle(300, 1'b1, POS_MAX);
    now_ms = 64;            send_angle(1000, 1'b0, '0);   // sum clips high
    now_ms = 65;            send_angle(2000, 1'b1, POS_MIN); // offset clips low
    now_ms = 66;            send_angle(100, 1'b0, '0);
    now_ms = 67;            send_angle(4095, 1'b0, '0);   // sum clips low
    now_ms = 68;            send_angle(4095, 1'b1, '0);
    now_ms = 69;            send_angle($urandom_range(0, 4095), 1'b1, -41'sd12345);
    now_ms = 32'hFFFF_FFF0; send_angle(1234, 1'b0, '0);
    now_ms = 32'h0000_0005; send_angle(1300, 1'b0, '0);   // elapsed across the wrap
    send_angle(1400, 1'b0, '0);
    send_frame('1, 1'b0, '1);
    send_frame('0, 1'b0, '0);
    send_angle($urandom_range(0, 4095), 1'b1, pick_target());

    for (phase_no = 0; phase_no < 14; phase_no++) begin
      drain();
      case (phase_no)
        0: program_regs(16'd4096, 12'd3896, 12'd200, 16'd20);
        1: program_regs(16'd0, 12'd4095, 12'd0, 16'd1);
        2: program_regs(16'hFFFF, 12'd0, 12'd4095, 16'hFFFF);
        3: program_regs(16'hFFFF, 12'd3896, 12'd200, 16'd1);
        4: program_regs(16'hFFFF, 12'd3000, 12'd1000, 16'd1);
        5: program_regs(16'd4096, 12'd3896, 12'd200, 16'd0);
        default: begin
          sens_v = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 20000));
          if ($urandom_range(0, 5) == 0) begin
            hi_v = 12'($urandom);
            lo_v = 12'($urandom);
          end else begin
            hi_v = 12'($urandom_range(2048, 4095));
            lo_v = 12'($urandom_range(0, 2047));
          end
          ivl_v = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
          program_regs(sens_v, hi_v, lo_v, ivl_v);
        end
      endcase
      calm = (phase_no == 2 || phase_no == 7);
      if (phase_no == 3 || phase_no == 4) begin
        sprint(phase_no == 3);
        target = sent + 20;
      end else begin
        target = sent + 95;
      end
      while (sent < target) mixed_item();
    end

    drain();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mat_pkg.sv
rtl/mat_mul.sv
rtl/mat_div.sv
rtl/multiturn_angle_tracker_top.sv
verif/angle_tracker_checker.sv
verif/testbench.sv
